// ----- rtl/fxa_pkg.sv -----
// Shared types and constants for the Q24.8 fixed-point ALU.
package fxa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W = 32;
    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int CELLS = NUM_W;
    localparam int CNT_W = 6;
    localparam int FP_SH_OFS = 150 - FRAC_BITS;
    localparam int OP_W = 4;
    localparam int IN_TDATA_W = 72;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_ADD        = 4'd0,
        OP_SUB        = 4'd1,
        OP_MUL        = 4'd2,
        OP_DIV        = 4'd3,
        OP_CMP        = 4'd4,
        OP_MIN        = 4'd5,
        OP_MAX        = 4'd6,
        OP_INC        = 4'd7,
        OP_DEC        = 4'd8,
        OP_FROM_INT   = 4'd9,
        OP_TO_INT     = 4'd10,
        OP_FROM_FLOAT = 4'd11,
        OP_TO_FLOAT   = 4'd12
    } op_t;

    // Item state as it moves down the cell chain.
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] res;
        logic              lt;
        logic              eq;
        logic              gt;
        logic              dz;
        logic              neg;
        logic [NUM_W-1:0]  nq;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] d;
        logic [CNT_W-1:0]  cnt;
    } work_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              a_less;
        logic              a_equal;
        logic              a_greater;
        logic              divide_by_zero;
    } res_t;

endpackage

// ----- rtl/fxa_front.sv -----
// Input stage: decode, simple operations, multiplier and FP32 to fixed conversion.
module fxa_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [fxa_pkg::OP_W-1:0]   in_op,
    input  logic signed [fxa_pkg::DATA_W-1:0] in_a,
    input  logic signed [fxa_pkg::DATA_W-1:0] in_b,
    output logic                       out_valid_reg,
    output fxa_pkg::work_t             out_work_reg
);
    import fxa_pkg::*;

    op_t                    op;
    logic [DATA_W-1:0]      abs_a;
    logic [DATA_W-1:0]      abs_b;
    logic signed [2*DATA_W-1:0] prod;
    logic                   lt;
    logic                   eq;
    logic                   gt;
    logic [DATA_W-1:0]      fp_res;
    logic [DATA_W-1:0]      simple_res;
    logic [7:0]             fe;
    logic [23:0]            fm;
    logic signed [9:0]      sh;
    logic [9:0]             rsh_amt;
    logic [55:0]            lsh;
    logic [23:0]            rsh;
    logic [24:0]            rmag;
    logic [DATA_W-1:0]      fmag;
    work_t                  work_next;

    assign op = op_t'(in_op);
    assign abs_a = in_a[DATA_W-1] ? (~in_a + 32'd1) : in_a;
    assign abs_b = in_b[DATA_W-1] ? (~in_b + 32'd1) : in_b;
    assign prod = in_a * in_b;
    assign lt = in_a < in_b;
    assign eq = in_a == in_b;
    assign gt = in_a > in_b;

    // FP32 to fixed, rounding half away from zero with saturation.
    always_comb begin
        fe = (in_a[30:23] == 8'd0) ? 8'd1 : in_a[30:23];
        fm = (in_a[30:23] == 8'd0) ? {1'b0, in_a[22:0]} : {1'b1, in_a[22:0]};
        sh = $signed({2'b00, fe}) - 10'(FP_SH_OFS);
        rsh_amt = 10'(-sh);
        lsh = {32'd0, fm} << sh[4:0];
        rsh = fm >> 5'(rsh_amt - 10'd1);
        rmag = {1'b0, rsh} + 25'd1;
        fmag = '0;
        if (in_a[30:23] == 8'hFF) begin
            if (in_a[22:0] != 23'd0) begin
                fp_res = '0;
            end else begin
                fp_res = in_a[DATA_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end else if (fm == 24'd0) begin
            fp_res = '0;
        end else if (sh >= 10'sd32 || (sh >= 10'sd0 && (|lsh[55:31]))) begin
            fp_res = in_a[DATA_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            if (sh >= 10'sd0) begin
                fmag = lsh[DATA_W-1:0];
            end else if (rsh_amt <= 10'd25) begin
                fmag = {8'd0, rmag[24:1]};
            end
            fp_res = in_a[DATA_W-1] ? (~fmag + 32'd1) : fmag;
        end
    end

    always_comb begin
        unique case (op)
            OP_ADD:        simple_res = in_a + in_b;
            OP_SUB:        simple_res = in_a - in_b;
            OP_MIN:        simple_res = lt ? in_a : in_b;
            OP_MAX:        simple_res = gt ? in_a : in_b;
            OP_INC:        simple_res = in_a + 32'd1;
            OP_DEC:        simple_res = in_a - 32'd1;
            OP_FROM_INT:   simple_res = in_a << FRAC_BITS;
            OP_TO_INT:     simple_res = in_a >>> FRAC_BITS;
            OP_FROM_FLOAT: simple_res = fp_res;
            default:       simple_res = '0;
        endcase
    end

    always_comb begin
        work_next.op  = op;
        work_next.res = simple_res;
        work_next.lt  = lt;
        work_next.eq  = eq;
        work_next.gt  = gt;
        work_next.dz  = (op == OP_DIV) && (in_b == '0);
        work_next.d   = abs_b;
        work_next.cnt = '0;
        work_next.rem = (op == OP_TO_FLOAT) ? abs_a : '0;
        if (op == OP_MUL) begin
            work_next.nq  = prod[NUM_W-1:0];
            work_next.neg = prod[2*DATA_W-1];
        end else begin
            work_next.nq  = NUM_W'(abs_a) << FRAC_BITS;
            work_next.neg = (op == OP_DIV) ? (in_a[DATA_W-1] ^ in_b[DATA_W-1])
                                           : in_a[DATA_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_work_reg <= work_next;
        end
    end

endmodule

// ----- rtl/fxa_cell.sv -----
// One chain cell: a restoring divide step or a one-bit normalize step.
module fxa_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  fxa_pkg::work_t in_work,
    output logic           out_valid_reg,
    output fxa_pkg::work_t out_work_reg
);
    import fxa_pkg::*;

    logic [DATA_W:0]   r2;
    logic [DATA_W+1:0] diff;
    logic              ge;
    work_t             work_next;

    assign r2 = {in_work.rem, in_work.nq[NUM_W-1]};
    assign diff = {1'b0, r2} - {2'b00, in_work.d};
    assign ge = !diff[DATA_W+1];

    always_comb begin
        work_next = in_work;
        if (in_work.op == OP_DIV) begin
            work_next.rem = ge ? diff[DATA_W-1:0] : r2[DATA_W-1:0];
            work_next.nq  = {in_work.nq[NUM_W-2:0], ge};
        end else if (in_work.op == OP_TO_FLOAT) begin
            // Shift until the leading one reaches the top bit.
            if (!in_work.rem[DATA_W-1] && in_work.rem != '0) begin
                work_next.rem = in_work.rem << 1;
                work_next.cnt = in_work.cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_work_reg <= work_next;
        end
    end

endmodule

// ----- rtl/fxa_back.sv -----
// Final rounding for multiply, divide and fixed to FP32, and result selection.
module fxa_back (
    input  fxa_pkg::work_t in_work,
    output fxa_pkg::res_t  out_res
);
    import fxa_pkg::*;

    logic [DATA_W-1:0] qq;
    logic              q_up;
    logic [NUM_W-1:0]  mmag;
    logic [NUM_W-1:0]  mround;
    logic [DATA_W-1:0] mres;
    logic [CNT_W-1:0]  p;
    logic [CNT_W-1:0]  p_adj;
    logic [23:0]       mant;
    logic              f_up;
    logic [24:0]       m25;
    logic [23:0]       mant_f;
    logic [7:0]        fexp;
    logic [DATA_W-1:0] fres;

    // Quotient rounding: step up when twice the remainder reaches the divisor.
    assign q_up = {in_work.rem, 1'b0} >= {1'b0, in_work.d};
    assign qq = in_work.nq[DATA_W-1:0] + DATA_W'(q_up);

    assign mmag = in_work.neg ? (~in_work.nq + NUM_W'(1)) : in_work.nq;
    assign mround = mmag + NUM_W'(1 << (FRAC_BITS - 1));
    assign mres = in_work.neg ? (~mround[NUM_W-1:FRAC_BITS] + 32'd1)
                              : mround[NUM_W-1:FRAC_BITS];

    always_comb begin
        p = CNT_W'(DATA_W - 1) - in_work.cnt;
        mant = in_work.rem[31:8];
        f_up = in_work.rem[7] && ((|in_work.rem[6:0]) || mant[0]);
        m25 = {1'b0, mant} + 25'(f_up);
        if (m25[24]) begin
            mant_f = m25[24:1];
            p_adj = p + CNT_W'(1);
        end else begin
            mant_f = m25[23:0];
            p_adj = p;
        end
        fexp = 8'(p_adj) + 8'(127 - FRAC_BITS);
        fres = (in_work.rem == '0) ? '0 : {in_work.neg, fexp, mant_f[22:0]};
    end

    always_comb begin
        out_res.a_less = in_work.lt;
        out_res.a_equal = in_work.eq;
        out_res.a_greater = in_work.gt;
        out_res.divide_by_zero = in_work.dz;
        unique case (in_work.op)
            OP_MUL:      out_res.result = mres;
            OP_DIV:      out_res.result = in_work.dz ? '0 :
                                          (in_work.neg ? (~qq + 32'd1) : qq);
            OP_TO_FLOAT: out_res.result = fres;
            default:     out_res.result = in_work.res;
        endcase
    end

endmodule

// ----- rtl/fixed_point_alu_q24_8_top.sv -----
// Top level of the Q24.8 fixed-point ALU: input stage, cell chain, rounding, output skid.
//
//  channel | direction | tdata fields (low bit first)
//  s_      | in        | req_type[3:0], operand_a[35:4], operand_b[67:36]
//  m_      | out       | result[31:0], a_less, a_equal, a_greater, divide_by_zero
//
// One transfer is accepted per cycle while the skid register is empty. Data passes
// through the input stage, 40 chain cells and the output register. The 40 cells are
// set by the 40-bit dividend, one quotient bit per cell; the same cells normalize
// for fixed to FP32. Reset clears all valid bits; no payload is reset.
// A stall on m_ is absorbed by a one-entry skid register; the chain holds only
// once the skid register is full.
module fixed_point_alu_q24_8_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // req_type, operand_a, operand_b
    input  logic [fxa_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result, a_less, a_equal, a_greater, divide_by_zero
    output logic [fxa_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import fxa_pkg::*;

    logic  adv;
    logic  valid_chain [0:CELLS];
    work_t work_chain  [0:CELLS];
    res_t  pipe_res;
    logic  pipe_valid;
    res_t  out_reg;
    res_t  skid_reg;
    logic  out_valid_reg;
    logic  skid_valid_reg;

    assign adv = !skid_valid_reg;
    assign s_tready = adv;

    fxa_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (s_tvalid),
        .in_op         (s_tdata[OP_W-1:0]),
        .in_a          (s_tdata[OP_W+DATA_W-1:OP_W]),
        .in_b          (s_tdata[OP_W+2*DATA_W-1:OP_W+DATA_W]),
        .out_valid_reg (valid_chain[0]),
        .out_work_reg  (work_chain[0])
    );

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        fxa_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .adv           (adv),
            .in_valid      (valid_chain[i]),
            .in_work       (work_chain[i]),
            .out_valid_reg (valid_chain[i+1]),
            .out_work_reg  (work_chain[i+1])
        );
    end

    fxa_back u_back (
        .in_work (work_chain[CELLS]),
        .out_res (pipe_res)
    );

    assign pipe_valid = valid_chain[CELLS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= pipe_valid;
        end else if (pipe_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_reg <= pipe_res;
        end else begin
            skid_reg <= pipe_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {4'd0, out_reg.divide_by_zero, out_reg.a_greater,
                      out_reg.a_equal, out_reg.a_less, out_reg.result};

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the Q24.8 fixed-point ALU stream block.
`timescale 1ns / 1ps

module tb;
    import fxa_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LATENCY = 42;
    localparam int N_RANDOM = 930;

    typedef struct packed {
        logic [31:0] result;
        logic        a_less;
        logic        a_equal;
        logic        a_greater;
        logic        divide_by_zero;
    } alu_out_t;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        bit          typed;
        alu_out_t    want;
    } vec_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    alu_out_t pending_results[$];
    int mismatches = 0;
    int cycles = 0;
    int accepted = 0;
    int received = 0;
    int div_zero_seen = 0;
    bit rx_stall_enable = 1'b1;

    fixed_point_alu_q24_8_top dut (.*);

    always #2 aclk = ~aclk;

    function automatic logic [31:0] fp32_to_q(logic [31:0] x);
        logic [7:0] e;
        logic [63:0] m;
        logic [63:0] mag;
        int sh;
        e = x[30:23];
        m = {41'd0, x[22:0]};
        if (e == 8'hFF) return (m != 0) ? 32'd0 : (x[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        if (e == 0) e = 8'd1;
        else m[23] = 1'b1;
        if (m == 0) return 32'd0;
        sh = int'(e) - 150 + FRAC_BITS;
        if (sh >= 32) mag = 64'd1 << 40;
        else if (sh >= 0) mag = m << sh;
        else if (-sh > 25) mag = 0;
        else mag = (m + (64'd1 << (-sh - 1))) >> (-sh);
        if (x[31]) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic [31:0] q_to_fp32(logic signed [31:0] a);
        logic [63:0] mag;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        int p;
        int s;
        mag = (a < 0) ? 64'(-64'(a)) : 64'(a);
        if (mag == 0) return 32'd0;
        p = 0;
        while ((mag >> (p + 1)) != 0) p++;
        if (p <= 23) begin
            mant = mag << (23 - p);
        end else begin
            s = p - 23;
            rem = mag & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            mant = mag >> s;
            if (rem > half || (rem == half && mant[0])) mant++;
            if (mant == (64'd1 << 24)) begin
                mant >>= 1;
                p++;
            end
        end
        return {a[31], 8'(p - FRAC_BITS + 127), mant[22:0]};
    endfunction

    function automatic alu_out_t alu_predict(logic [3:0] op, logic [31:0] ua, logic [31:0] ub);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] prod;
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] den;
        alu_out_t r;
        a = ua;
        b = ub;
        r = '0;
        case (op)
            OP_ADD: r.result = ua + ub;
            OP_SUB: r.result = ua - ub;
            OP_MUL: begin
                prod = 64'(a) * 64'(b);
                mag = (prod < 0) ? -prod : prod;
                mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r.result = (prod < 0) ? -mag[31:0] : mag[31:0];
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    num = ((a < 0) ? 64'(-64'(a)) : 64'(a)) << FRAC_BITS;
                    den = (b < 0) ? 64'(-64'(b)) : 64'(b);
                    mag = (2 * num + den) / (2 * den);
                    r.result = ((a < 0) != (b < 0)) ? -mag[31:0] : mag[31:0];
                end
            end
            OP_MIN: r.result = (a < b) ? ua : ub;
            OP_MAX: r.result = (a > b) ? ua : ub;
            OP_INC: r.result = ua + 1;
            OP_DEC: r.result = ua - 1;
            OP_FROM_INT: r.result = ua << FRAC_BITS;
            OP_TO_INT: r.result = a >>> FRAC_BITS;
            OP_FROM_FLOAT: r.result = fp32_to_q(ua);
            OP_TO_FLOAT: r.result = q_to_fp32(a);
            default: r.result = '0;
        endcase
        r.a_less = a < b;
        r.a_equal = a == b;
        r.a_greater = a > b;
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 2048)) - 1024);
            3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_float();
        logic [31:0] f;
        f = $urandom;
        // Keep most exponents near the range the Q24.8 format can hold.
        case ($urandom_range(0, 5))
            0: f[30:23] = 8'hFF;
            1: f[30:23] = 8'h00;
            2: f[30:23] = 8'($urandom_range(140, 175));
            default: f[30:23] = 8'($urandom_range(100, 160));
        endcase
        return f;
    endfunction

    task automatic send(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, b, a, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Expectations are queued at the accepting edge so the order matches the stream.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            pending_results.push_back(alu_predict(s_tdata[3:0], s_tdata[35:4],
                                                  s_tdata[67:36]));
            accepted++;
        end
    end

    always @(posedge aclk) begin
        alu_out_t got;
        alu_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[34], m_tdata[35]};
            received++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer %h", got);
            end else begin
                want = pending_results.pop_front();
                if (want.divide_by_zero) div_zero_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch #%0d: result exp %h got %h, ",
                                  "lt/eq/gt/dz exp %b%b%b%b got %b%b%b%b"},
                                 received, want.result, got.result, want.a_less,
                                 want.a_equal, want.a_greater, want.divide_by_zero,
                                 got.a_less, got.a_equal, got.a_greater,
                                 got.divide_by_zero);
                end
            end
        end
    end

    // Receiver back-pressure, with quiet stretches where it always accepts.
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            g = rx_stall_enable ? gap_len() : 0;
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(negedge aclk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("** fixed_point_alu_q24_8_top: FAILED **");
            $finish;
        end
    end

    initial begin
        vec_t table_rows[$];
        vec_t v;
        logic [3:0] op;
        logic [31:0] a;
        logic [31:0] b;
        table_rows = '{
            '{OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1'b0, 1'b0, 1'b1, 1'b0}},
            '{OP_SUB, 32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{OP_MUL, 32'h0000_0180, 32'h0000_0200, 1'b1, '{32'h0000_0300, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{OP_MUL, 32'h0000_0001, 32'h0000_0080, 1'b0, '0},
            '{OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080, 1'b0, '0},
            '{OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
            '{OP_DIV, 32'h0000_0100, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b1, 1'b1}},
            '{OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_DIV, 32'h0000_0001, 32'h0000_0200, 1'b0, '0},
            '{OP_DIV, 32'hFFFF_FFFD, 32'h0000_0600, 1'b0, '0},
            '{OP_CMP, 32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 1'b0}},
            '{OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{OP_MIN, 32'h0000_0042, 32'h0000_0042, 1'b0, '0},
            '{OP_INC, 32'h7FFF_FFFF, 32'h0, 1'b1, '{32'h8000_0000, 1'b0, 1'b0, 1'b1, 1'b0}},
            '{OP_DEC, 32'h8000_0000, 32'h0, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{OP_FROM_INT, 32'hFFFF_FFFF, 32'h0, 1'b1, '{32'hFFFF_FF00, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{OP_TO_INT, 32'hFFFF_FFFF, 32'h0, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{OP_FROM_FLOAT, 32'h7F80_0000, 32'h0, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0}},
            '{OP_FROM_FLOAT, 32'hFF80_0000, 32'h0, 1'b1, '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{OP_FROM_FLOAT, 32'h7FC0_0001, 32'h0, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b1, 1'b0}},
            '{OP_FROM_FLOAT, 32'h8000_0000, 32'h0, 1'b1, '{32'h0, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{OP_FROM_FLOAT, 32'hBB80_0000, 32'h0, 1'b0, '0},
            '{OP_TO_FLOAT, 32'h0000_0000, 32'h0, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 1'b0}},
            '{OP_TO_FLOAT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
            '{4'hF, 32'h1234_5678, 32'h1234_5678, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 1'b0}}
        };
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (table_rows[i]) begin
            v = table_rows[i];
            send(v.op, v.a, v.b);
            // Typed rows must also agree with the predictor; a disagreement is a bench bug.
            if (v.typed && alu_predict(v.op, v.a, v.b) !== v.want) begin
                mismatches++;
                $display("table row %0d disagrees with the predictor", i);
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // Drain the pipeline completely before resuming.
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(negedge aclk);
            end
            rx_stall_enable = !(n >= 300 && n < 400);
            op = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 9) != 0 && op > OP_TO_FLOAT) op = 4'($urandom_range(0, 12));
            a = (op == OP_FROM_FLOAT) ? rand_float() : rand_operand();
            b = ($urandom_range(0, 7) == 0) ? a : rand_operand();
            if (op == OP_DIV && $urandom_range(0, 7) == 0) b = '0;
            send(op, a, b);
        end
        s_tvalid <= 1'b0;
        rx_stall_enable = 1'b1;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);

        $display("Covered %0d transfers: all opcodes including undefined ones, operand extremes,",
                 accepted);
        $display("float specials, %0d divides by zero, random gaps and back-pressure.",
                 div_zero_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** fixed_point_alu_q24_8_top: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     pending_results.size());
            $display("** fixed_point_alu_q24_8_top: FAILED **");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/fxa_pkg.sv
rtl/fxa_front.sv
rtl/fxa_cell.sv
rtl/fxa_back.sv
rtl/fixed_point_alu_q24_8_top.sv
test/tb.sv
